### rtl/oxd_pkg.sv
// Shared constants and types for the field-oriented omni X-drive mixer.
package oxd_pkg;

    // Trig word: FRAC_BITS fraction bits, signed range [-1.0, +1.0] exact.
    localparam int TRIG_BITS = 16;
    localparam int FRAC_BITS = TRIG_BITS - 1;
    localparam int TW        = TRIG_BITS + 1;

    // Horner chain: cos uses all steps, sin one fewer plus the final x multiply.
    localparam int HSTEPS    = 7;
    localparam int SIN_STEPS = 6;

    // Trig unit: angle, square, three registers per Horner step, round, quadrant.
    localparam int TRIG_LAT  = 2 + 3 * HSTEPS + 2;
    // Whole datapath: trig plus rotate (2), mix (1), gain (2).
    localparam int PIPE_LAT  = TRIG_LAT + 5;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Series divisors with floor(2^sh / d) reciprocals; a one-step fixup
    // after the multiply makes the quotient exact for any 32-bit dividend.
    localparam logic [7:0]  SIN_DIV [SIN_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
        32'd1762037865, 32'd1249445031, 32'd1908874353,
        32'd1636178017, 32'd1717986918, 32'd1431655765};
    localparam int          SIN_SH  [SIN_STEPS] = '{38, 37, 37, 36, 35, 33};

    localparam logic [7:0]  COS_DIV [HSTEPS] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] COS_RCP [HSTEPS] = '{
        32'd1510318170, 32'd2082408385, 32'd1527099483, 32'd1227133513,
        32'd1145324612, 32'd1431655765, 32'd2147483648};
    localparam int          COS_SH  [HSTEPS] = '{38, 38, 37, 36, 35, 34, 32};

    // Configuration register indexes.
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_HALF_SPAN  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_WHEEL_GAIN = 2'd1;

    typedef logic signed [TW-1:0] t_trig;

endpackage

### rtl/oxd_trig.sv
// Pipelined sine/cosine of a 16-bit heading by truncating Horner series.
module oxd_trig import oxd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_heading,
    output t_trig       o_sin,
    output t_trig       o_cos
);

    localparam logic [1:0] Q_FIRST  = 2'd0;
    localparam logic [1:0] Q_SECOND = 2'd1;
    localparam logic [1:0] Q_THIRD  = 2'd2;
    localparam logic [1:0] Q_FOURTH = 2'd3;

    localparam logic [FRAC_BITS:0] TRIG_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic [1:0]  quad;
        logic [30:0] x;
        logic [31:0] x2;
    } t_ctx;

    // Q2.30 -> FRAC_BITS, round half up, clamp to 1.0
    function automatic logic [FRAC_BITS:0] to_trig(logic [30:0] q);
        logic [31:0] v;
        v = (32'(q) + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return (v > 32'(TRIG_ONE)) ? TRIG_ONE : v[FRAC_BITS:0];
    endfunction

    logic [1:0]  r_quad1;
    logic [30:0] r_x1;
    t_ctx        r_ctx2;
    logic [45:0] w_xprod;
    logic [61:0] w_xsq;

    assign w_xprod = 46'(i_heading[13:0]) * 46'(PI_Q30);
    assign w_xsq   = 62'(r_x1) * 62'(r_x1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad1 <= i_heading[15:14];
            r_x1    <= w_xprod[45:15];
            r_ctx2  <= '{quad: r_quad1, x: r_x1, x2: w_xsq[61:30]};
        end
    end

    t_ctx        r_ctx_a [HSTEPS];
    t_ctx        r_ctx_b [HSTEPS];
    t_ctx        r_ctx_c [HSTEPS];
    logic [31:0] r_cv_a  [HSTEPS];
    logic [31:0] r_cv_b  [HSTEPS];
    logic [31:0] r_cq_b  [HSTEPS];
    logic [30:0] r_ct_c  [HSTEPS];
    logic [31:0] r_sv_a  [HSTEPS];
    logic [31:0] r_sv_b  [HSTEPS];
    logic [31:0] r_sq_b  [SIN_STEPS];
    logic [30:0] r_st_c  [HSTEPS];

    // Each step: a) x2*t, b) reciprocal multiply, c) fixup and 1 - q
    for (genvar j = 0; j < HSTEPS; j++) begin : g_step
        t_ctx        w_ctx_in;
        logic [30:0] w_ct_in;
        logic [30:0] w_st_in;
        logic [62:0] w_cprod;
        logic [63:0] w_crcp;
        logic [31:0] w_crem;
        logic [31:0] w_cq;
        logic [30:0] w_ct_nxt;

        if (j == 0) begin : g_first
            assign w_ctx_in = r_ctx2;
            assign w_ct_in  = ONE_Q30;
            assign w_st_in  = ONE_Q30;
        end else begin : g_next
            assign w_ctx_in = r_ctx_c[j-1];
            assign w_ct_in  = r_ct_c[j-1];
            assign w_st_in  = r_st_c[j-1];
        end

        assign w_cprod  = 63'(w_ctx_in.x2) * 63'(w_ct_in);
        assign w_crcp   = 64'(r_cv_a[j]) * 64'(COS_RCP[j]);
        assign w_crem   = r_cv_b[j] - r_cq_b[j] * 32'(COS_DIV[j]);
        assign w_cq     = (w_crem >= 32'(COS_DIV[j])) ? r_cq_b[j] + 32'd1 : r_cq_b[j];
        assign w_ct_nxt = (w_cq >= 32'(ONE_Q30)) ? '0 : ONE_Q30 - w_cq[30:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx_a[j] <= w_ctx_in;
                r_ctx_b[j] <= r_ctx_a[j];
                r_ctx_c[j] <= r_ctx_b[j];
                r_cv_a[j]  <= w_cprod[61:30];
                r_cv_b[j]  <= r_cv_a[j];
                r_cq_b[j]  <= 32'(w_crcp >> COS_SH[j]);
                r_ct_c[j]  <= w_ct_nxt;
            end
        end

        if (j < SIN_STEPS) begin : g_sin_series
            logic [62:0] w_sprod;
            logic [63:0] w_srcp;
            logic [31:0] w_srem;
            logic [31:0] w_sq;
            logic [30:0] w_st_nxt;

            assign w_sprod  = 63'(w_ctx_in.x2) * 63'(w_st_in);
            assign w_srcp   = 64'(r_sv_a[j]) * 64'(SIN_RCP[j]);
            assign w_srem   = r_sv_b[j] - r_sq_b[j] * 32'(SIN_DIV[j]);
            assign w_sq     = (w_srem >= 32'(SIN_DIV[j])) ? r_sq_b[j] + 32'd1 : r_sq_b[j];
            assign w_st_nxt = (w_sq >= 32'(ONE_Q30)) ? '0 : ONE_Q30 - w_sq[30:0];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sv_a[j] <= w_sprod[61:30];
                    r_sv_b[j] <= r_sv_a[j];
                    r_sq_b[j] <= 32'(w_srcp >> SIN_SH[j]);
                    r_st_c[j] <= w_st_nxt;
                end
            end
        end else begin : g_sin_final
            // sin = x * series, result stays below 2^31
            logic [62:0] w_sprod;

            assign w_sprod = 63'(w_ctx_in.x) * 63'(w_st_in);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sv_a[j] <= w_sprod[61:30];
                    r_sv_b[j] <= r_sv_a[j];
                    r_st_c[j] <= r_sv_b[j][30:0];
                end
            end
        end
    end

    logic [FRAC_BITS:0] r_smag;
    logic [FRAC_BITS:0] r_cmag;
    logic [1:0]         r_quad_r;
    t_trig              r_sin;
    t_trig              r_cos;
    t_trig              w_s;
    t_trig              w_c;
    t_trig              w_sin_nxt;
    t_trig              w_cos_nxt;

    assign w_s = t_trig'({1'b0, r_smag});
    assign w_c = t_trig'({1'b0, r_cmag});

    always_comb begin
        unique case (r_quad_r)
            Q_FIRST:  begin w_sin_nxt = w_s;  w_cos_nxt = w_c;  end
            Q_SECOND: begin w_sin_nxt = w_c;  w_cos_nxt = -w_s; end
            Q_THIRD:  begin w_sin_nxt = -w_s; w_cos_nxt = -w_c; end
            Q_FOURTH: begin w_sin_nxt = -w_c; w_cos_nxt = w_s;  end
            default:  begin w_sin_nxt = w_s;  w_cos_nxt = w_c;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_smag   <= to_trig(r_st_c[HSTEPS-1]);
            r_cmag   <= to_trig(r_ct_c[HSTEPS-1]);
            r_quad_r <= r_ctx_c[HSTEPS-1].quad;
            r_sin    <= w_sin_nxt;
            r_cos    <= w_cos_nxt;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### rtl/omni_x_drive_field_oriented_mix.sv
// Top level: field-oriented omni X-drive mixer with stream ports and config port.
//
// Input stream (s_axis): one word per command: field-frame vx, vy (mm/s),
// spin (mrad/s) and heading (65536 codes per turn). Output stream (m_axis):
// one word per command with the four saturated wheel speeds a..d.
// Config port: i_cfg_addr 0 = half_span_mm (10 bits), 1 = wheel_gain_q12
// (16 bits, Q4.12); other addresses are dropped. o_cfg_ready is always high.
// Write config only while no command is in flight.
//
// Throughput: one word per clock while m_axis accepts. Commands cross the
// 30-register datapath (mostly the seven-step Horner chain of the trig
// unit, three registers per step) and then the output register.
// All stages advance together. When m_axis stalls, the word leaving the
// datapath parks in a one-word skid register; s_axis_tready drops while
// the skid is full and the datapath freezes, so nothing is lost or repeated.
// Reset (synchronous, active low) empties the datapath and output and loads
// half_span_mm = 300, wheel_gain_q12 = 4096.
module omni_x_drive_field_oriented_mix import oxd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // cmd_vx, cmd_vy, cmd_spin, heading
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // wheel_a, wheel_b, wheel_c, wheel_d
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]       i_cfg_data
);

    localparam int PW = 16 + TW;   // velocity x trig
    localparam int RW = 19;        // rotated velocity
    localparam int MW = RW + 2;    // wheel sum
    localparam int GW = MW + 17;   // wheel sum x gain
    localparam int SPIN_DIV = 1000;
    localparam logic [25:0] SPIN_RCP = 26'd34359738;   // floor(2^35 / 1000)
    localparam logic signed [PW:0] RND_HALF =
        {{(PW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [GW:0] SAT_HI = (GW + 1)'(32767);
    localparam logic signed [GW:0] SAT_LO = (GW + 1)'(-32768);

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
    } t_vel;

    typedef struct packed {
        t_vel               vel;
        logic signed [16:0] sp;
    } t_cmd;

    // ---------------- configuration ----------------
    logic [9:0]  r_half_span;
    logic [15:0] r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_span <= 10'd300;
            r_gain      <= 16'd4096;
        end else if (i_cfg_valid) begin
            if (i_cfg_addr == CFG_HALF_SPAN) begin
                r_half_span <= i_cfg_data[9:0];
            end else if (i_cfg_addr == CFG_WHEEL_GAIN) begin
                r_gain <= i_cfg_data;
            end
        end
    end

    // ---------------- global advance, valid line ----------------
    logic                r_skid_vld;
    logic                r_out_vld;
    logic                w_adv;
    logic [PIPE_LAT-1:0] r_vld;

    assign w_adv         = !r_skid_vld;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- trig unit ----------------
    t_trig w_sin;
    t_trig w_cos;

    oxd_trig u_trig (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_heading (s_axis_tdata[63:48]),
        .o_sin     (w_sin),
        .o_cos     (w_cos)
    );

    // ---------------- spin term, stages 1-4 ----------------
    // sp = spin * half_span / 1000, rounded half away from zero
    t_vel               r_s1_vel;
    t_vel               r_s2_vel;
    t_vel               r_s3_vel;
    logic signed [26:0] r_s1_p;
    logic               r_s2_neg;
    logic [25:0]        r_s2_mag;
    logic               r_s3_neg;
    logic [25:0]        r_s3_mag;
    logic [15:0]        r_s3_q0;
    logic signed [26:0] w_spin_p;
    logic [26:0]        w_pabs;
    logic [51:0]        w_sprod;
    logic [25:0]        w_srem;
    logic [16:0]        w_sq;
    t_cmd               w_cmd4;

    assign w_spin_p = 27'($signed(s_axis_tdata[47:32])) * 27'($signed({1'b0, r_half_span}));
    assign w_pabs   = r_s1_p[26] ? 27'(-r_s1_p) : 27'(r_s1_p);
    assign w_sprod  = 52'(r_s2_mag) * 52'(SPIN_RCP);
    assign w_srem   = r_s3_mag - 26'(r_s3_q0) * 26'(SPIN_DIV);
    assign w_sq     = (w_srem >= 26'(SPIN_DIV)) ? 17'(r_s3_q0) + 17'd1 : 17'(r_s3_q0);

    assign w_cmd4.vel = r_s3_vel;
    assign w_cmd4.sp  = r_s3_neg ? -$signed(w_sq) : $signed(w_sq);

    // align with trig output
    t_cmd r_dl [TRIG_LAT-3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_vel <= '{vx: s_axis_tdata[15:0], vy: s_axis_tdata[31:16]};
            r_s1_p   <= w_spin_p;
            r_s2_vel <= r_s1_vel;
            r_s2_neg <= r_s1_p[26];
            r_s2_mag <= w_pabs[25:0] + 26'd500;
            r_s3_vel <= r_s2_vel;
            r_s3_neg <= r_s2_neg;
            r_s3_mag <= r_s2_mag;
            r_s3_q0  <= w_sprod[50:35];
            r_dl[0]  <= w_cmd4;
            for (int k = 1; k < TRIG_LAT - 3; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // ---------------- rotation and mix ----------------
    t_cmd                  w_cmd_t;
    logic signed [PW-1:0]  r_pxc;
    logic signed [PW-1:0]  r_pys;
    logic signed [PW-1:0]  r_pyc;
    logic signed [PW-1:0]  r_pxs;
    logic signed [16:0]    r_r1_sp;
    logic signed [16:0]    r_r2_sp;
    logic signed [RW-1:0]  r_rx;
    logic signed [RW-1:0]  r_ry;
    logic signed [PW:0]    w_rx_sum;
    logic signed [PW:0]    w_ry_sum;
    logic signed [MW-1:0]  r_m  [4];
    logic signed [GW-1:0]  r_w1 [4];
    logic [15:0]           r_w2 [4];
    logic signed [GW:0]    w_rnd [4];

    assign w_cmd_t  = r_dl[TRIG_LAT-4];
    assign w_rx_sum = (PW + 1)'(r_pxc) + (PW + 1)'(r_pys) + RND_HALF;
    assign w_ry_sum = (PW + 1)'(r_pyc) - (PW + 1)'(r_pxs) + RND_HALF;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rnd[i] = ((GW + 1)'(r_w1[i]) + (GW + 1)'(2048)) >>> 12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pxc   <= PW'(w_cmd_t.vel.vx) * PW'(w_cos);
            r_pys   <= PW'(w_cmd_t.vel.vy) * PW'(w_sin);
            r_pyc   <= PW'(w_cmd_t.vel.vy) * PW'(w_cos);
            r_pxs   <= PW'(w_cmd_t.vel.vx) * PW'(w_sin);
            r_r1_sp <= w_cmd_t.sp;
            r_rx    <= RW'(w_rx_sum >>> FRAC_BITS);
            r_ry    <= RW'(w_ry_sum >>> FRAC_BITS);
            r_r2_sp <= r_r1_sp;
            // wheel a..d: sign pattern of rx, ry; spin term always subtracted
            r_m[0]  <= -MW'(r_rx) + MW'(r_ry) - MW'(r_r2_sp);
            r_m[1]  <= -MW'(r_rx) - MW'(r_ry) - MW'(r_r2_sp);
            r_m[2]  <=  MW'(r_rx) - MW'(r_ry) - MW'(r_r2_sp);
            r_m[3]  <=  MW'(r_rx) + MW'(r_ry) - MW'(r_r2_sp);
            for (int i = 0; i < 4; i++) begin
                r_w1[i] <= GW'(r_m[i]) * GW'($signed({1'b0, r_gain}));
                if (w_rnd[i] > SAT_HI) begin
                    r_w2[i] <= 16'h7FFF;
                end else if (w_rnd[i] < SAT_LO) begin
                    r_w2[i] <= 16'h8000;
                end else begin
                    r_w2[i] <= w_rnd[i][15:0];
                end
            end
        end
    end

    // ---------------- output register and skid ----------------
    logic        w_push;
    logic [63:0] w_push_data;
    logic [63:0] r_out_data;
    logic [63:0] r_skid_data;

    assign w_push      = w_adv && r_vld[PIPE_LAT-1];
    assign w_push_data = {r_w2[3], r_w2[2], r_w2[1], r_w2[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_push;
            end
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || m_axis_tready) begin
            r_out_data <= r_skid_vld ? r_skid_data : w_push_data;
        end else if (w_push) begin
            r_skid_data <= w_push_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // ---------------- checks ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a word while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !m_axis_tready && r_vld[PIPE_LAT-1]))
        else $error("skid filled without a stalled output and a finished word");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_vld[PIPE_LAT-1]))
        else $error("output became valid without a word leaving the datapath");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_gain == '0)) |=>
        (r_w1[0] == '0 && r_w1[1] == '0 && r_w1[2] == '0 && r_w1[3] == '0))
        else $error("nonzero gain product with zero gain");

endmodule

### sim/tb_omni_x_drive_field_oriented_mix.sv
// Self-checking testbench for the field-oriented omni X-drive wheel mixer.
`timescale 1ns / 1ps

module tb_omni_x_drive_field_oriented_mix;
    import oxd_pkg::*;

    // Run limit in clocks; the slowest correct run ends well before it.
    localparam int CYCLE_LIMIT = 200000;
    // Drain time after the last expected word: full pipe plus skid slack.
    localparam int DRAIN_CYCLES = PIPE_LAT + 8;
    localparam int RANDOM_PER_PHASE = 325;
    localparam int MAX_REPORTS = 10;

    // Addresses past the register list; writes there must be dropped.
    localparam logic [CFG_AW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SPARE_B = 2'd3;

    // Series constants, Q2.30 angle arithmetic.
    localparam longint SERIES_ONE = 64'sd1 << 30;
    localparam longint ANGLE_PI   = 64'sd3373259426;
    localparam longint SIN_DIVS [6] = '{156, 110, 72, 42, 20, 6};
    localparam longint COS_DIVS [7] = '{182, 132, 90, 56, 30, 12, 2};

    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_t;

    // Command word, vx in the low bits, heading in the high bits.
    typedef struct packed {
        logic        [15:0] heading;
        logic signed [15:0] spin;
        logic signed [15:0] vy;
        logic signed [15:0] vx;
    } cmd_t;

    // Wheel word, wheel a in the low bits.
    typedef struct packed {
        logic signed [15:0] d;
        logic signed [15:0] c;
        logic signed [15:0] b;
        logic signed [15:0] a;
    } wheel_set_t;

    // Keeps its own register copy, predicts wheel speeds per accepted
    // command and checks returned words in order.
    class wheel_speed_scoreboard;
        longint     half_span;
        longint     gain;
        wheel_set_t expected_wheels[$];
        int         mismatches;

        function new();
            half_span  = 300;
            gain       = 4096;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] addr, logic [15:0] data);
            case (addr)
                CFG_HALF_SPAN:  half_span = longint'(data[9:0]);
                CFG_WHEEL_GAIN: gain      = longint'(data);
                default: ;
            endcase
        endfunction

        // Truncating Horner series; each step clamps at zero.
        function longint series(longint x2, bit is_cos);
            longint t;
            longint sub;
            int     steps;
            t = SERIES_ONE;
            steps = is_cos ? 7 : 6;
            for (int i = 0; i < steps; i++) begin
                sub = ((x2 * t) >>> 30) / (is_cos ? COS_DIVS[i] : SIN_DIVS[i]);
                t = (sub >= SERIES_ONE) ? 64'sd0 : SERIES_ONE - sub;
            end
            return t;
        endfunction

        // Q2.30 to trig word: round half up, clamp at exactly 1.0.
        function longint to_trig(longint q30);
            longint v;
            longint unity;
            unity = 64'sd1 << FRAC_BITS;
            v = (q30 + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            return (v > unity) ? unity : v;
        endfunction

        function void unit_vector(logic [15:0] heading, output longint sn,
                                  output longint cs);
            longint x;
            longint x2;
            longint s0;
            longint c0;
            x  = (longint'(heading[13:0]) * ANGLE_PI) >>> 15;
            x2 = (x * x) >>> 30;
            s0 = to_trig((x * series(x2, 1'b0)) >>> 30);
            c0 = to_trig(series(x2, 1'b1));
            case (quadrant_t'(heading[15:14]))
                QUAD_0: begin
                    sn = s0;  cs = c0;
                end
                QUAD_90: begin
                    sn = c0;  cs = -s0;
                end
                QUAD_180: begin
                    sn = -s0; cs = -c0;
                end
                default: begin
                    sn = -c0; cs = s0;
                end
            endcase
        endfunction

        // Gain, round half up by 12 bits, saturate to 16 bits.
        function logic signed [15:0] wheel_speed(longint m);
            longint v;
            v = (m * gain + 2048) >>> 12;
            if (v > 32767)
                v = 32767;
            else if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        function wheel_set_t mix_wheels(cmd_t cmd);
            longint     vx;
            longint     vy;
            longint     p;
            longint     sp;
            longint     sn;
            longint     cs;
            longint     rx;
            longint     ry;
            longint     half;
            wheel_set_t w;
            vx   = longint'(cmd.vx);
            vy   = longint'(cmd.vy);
            half = 64'sd1 << (FRAC_BITS - 1);
            unit_vector(cmd.heading, sn, cs);
            rx = (vx * cs + vy * sn + half) >>> FRAC_BITS;
            ry = (vy * cs - vx * sn + half) >>> FRAC_BITS;
            // spin term rounds half away from zero
            p  = longint'(cmd.spin) * half_span;
            sp = (p >= 0) ? (p + 500) / 1000 : -((-p + 500) / 1000);
            w.a = wheel_speed(-rx + ry - sp);
            w.b = wheel_speed(-rx - ry - sp);
            w.c = wheel_speed(rx - ry - sp);
            w.d = wheel_speed(rx + ry - sp);
            return w;
        endfunction

        function void note_command(cmd_t cmd);
            expected_wheels.push_back(mix_wheels(cmd));
        endfunction

        function void flag(string what, wheel_set_t exp, wheel_set_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s: exp a=%0d b=%0d c=%0d d=%0d got a=%0d b=%0d c=%0d d=%0d",
                         what, exp.a, exp.b, exp.c, exp.d, got.a, got.b, got.c, got.d);
        endfunction

        function void check_wheels(logic [63:0] word);
            wheel_set_t got;
            wheel_set_t exp;
            got = word;
            if (expected_wheels.size() == 0) begin
                flag("wheel word with no command pending", '0, got);
                return;
            end
            exp = expected_wheels.pop_front();
            if (got.a !== exp.a || got.b !== exp.b || got.c !== exp.c || got.d !== exp.d)
                flag("wheel mismatch", exp, got);
        endfunction

        function int pending();
            return expected_wheels.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;      // cmd_vx, cmd_vy, cmd_spin, heading
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;           // wheel_a, wheel_b, wheel_c, wheel_d
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [15:0]       i_cfg_data = '0;

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                cycle_count = 0;
    wheel_speed_scoreboard wheel_sb;

    omni_x_drive_field_oriented_mix DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: check the word accepted at this edge, then pick the next
    // ready value. Everything sampled here is the pre-edge value.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            wheel_sb.check_wheels(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic cmd_t pack_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
                                      logic signed [15:0] spin, logic [15:0] heading);
        cmd_t c;
        c.vx      = vx;
        c.vy      = vy;
        c.spin    = spin;
        c.heading = heading;
        return c;
    endfunction

    // Mix of full-range, small and extreme speeds so that some words
    // saturate and some stay in the linear range.
    function automatic logic signed [15:0] rand_speed();
        logic [15:0] v;
        case ($urandom_range(9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2, 3, 4: begin
                v = 16'($urandom_range(600));
                v = v - 16'd300;
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Mostly any angle; some right at quadrant boundaries.
    function automatic logic [15:0] rand_heading();
        logic [15:0] h;
        if ($urandom_range(4) == 0) begin
            h = {2'($urandom), 14'd0};
            h = h + 16'($urandom_range(2)) - 16'd1;
        end else begin
            h = 16'($urandom);
        end
        return h;
    endfunction

    // One command word; valid stays high across back-to-back words.
    task automatic send_cmd(input cmd_t cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        wheel_sb.note_command(cmd);
    endtask

    // Drop valid and wait until every expected wheel word is back.
    task automatic finish_stream();
        s_axis_tvalid <= 1'b0;
        while (wheel_sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Config write; valid is left high so writes can go back to back.
    task automatic put_reg(input logic [CFG_AW-1:0] addr, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        wheel_sb.set_reg(addr, data);
    endtask

    // Both registers, plus writes to unused addresses that must change nothing.
    task automatic apply_config(input logic [15:0] half_span, input logic [15:0] gain);
        put_reg(CFG_SPARE_A, 16'($urandom));
        put_reg(CFG_HALF_SPAN, half_span);
        put_reg(CFG_WHEEL_GAIN, gain);
        put_reg(CFG_SPARE_B, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (RANDOM_PER_PHASE)
            send_cmd(pack_cmd(rand_speed(), rand_speed(), rand_speed(), rand_heading()));
        finish_stream();
    endtask

    initial begin
        cmd_t directed_cmds[$];

        wheel_sb = new();

        // Directed words under reset config (span 300, unity gain).
        directed_cmds.push_back(pack_cmd(0, 0, 0, 16'd0));
        // one vector at heading 0 and the quadrant starts, another at 45 degrees
        directed_cmds.push_back(pack_cmd(1000, 0, 0, 16'd0));
        directed_cmds.push_back(pack_cmd(1000, 0, 0, 16'd16384));
        directed_cmds.push_back(pack_cmd(1000, 0, 0, 16'd32768));
        directed_cmds.push_back(pack_cmd(1000, 0, 0, 16'd49152));
        directed_cmds.push_back(pack_cmd(1000, 500, 0, 16'd8192));
        // last code of a quadrant, last code of the turn
        directed_cmds.push_back(pack_cmd(1000, 500, 0, 16'd16383));
        directed_cmds.push_back(pack_cmd(-1000, 700, 0, 16'hFFFF));
        // full-scale fields, driving the wheels into saturation
        directed_cmds.push_back(pack_cmd(32767, 32767, 32767, 16'd0));
        directed_cmds.push_back(pack_cmd(-32768, -32768, -32768, 16'd0));
        directed_cmds.push_back(pack_cmd(32767, -32768, 0, 16'd8192));
        directed_cmds.push_back(pack_cmd(-32768, 32767, -32768, 16'd24576));
        // spin term on an exact half, both signs
        directed_cmds.push_back(pack_cmd(0, 0, 5, 16'd0));
        directed_cmds.push_back(pack_cmd(0, 0, -5, 16'd0));
        directed_cmds.push_back(pack_cmd(0, 0, 32767, 16'd0));
        directed_cmds.push_back(pack_cmd(0, 0, -32768, 16'd40000));
        // tiny vectors where the rotation rounding decides the result
        directed_cmds.push_back(pack_cmd(1, 0, 0, 16'd1));
        directed_cmds.push_back(pack_cmd(3, -3, 0, 16'd40960));
        directed_cmds.push_back(pack_cmd(-1, 1, 1, 16'd57344));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i]);
        finish_stream();

        // zero lever arm, largest gain; no idling
        apply_config(16'h0000, 16'hFFFF);
        run_random(0, 0);

        // all-ones write keeps only the low 10 bits; zero gain; sender idles
        apply_config(16'hFFFF, 16'h0000);
        run_random(82, 0);

        // random span with junk upper bits, gain one half (rounding ties)
        apply_config(16'($urandom), 16'd2048);
        run_random(0, 82);

        // moderate random gain, both sides idle now and then
        apply_config(16'($urandom_range(1023)), 16'($urandom_range(12000, 2000)));
        run_random(19, 19);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (wheel_sb.mismatches == 0 && wheel_sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/oxd_pkg.sv
rtl/oxd_trig.sv
rtl/omni_x_drive_field_oriented_mix.sv
sim/tb_omni_x_drive_field_oriented_mix.sv
